// File: src/dapv_pkg.sv
package dapv_pkg;

	localparam int KIND_W     = 2;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_TARGET   = 2'd0,
		KIND_FEEDBACK = 2'd1,
		KIND_TICK     = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP   = 3'd0,
		CFG_KI   = 3'd1,
		CFG_KD   = 3'd2,
		CFG_LLIM = 3'd3,
		CFG_ALIM = 3'd4
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0] KP_RESET   = 16'd256;
	localparam logic [GAIN_W-1:0] KI_RESET   = 16'd0;
	localparam logic [GAIN_W-1:0] KD_RESET   = 16'd26;
	localparam logic [LIM_W-1:0]  LLIM_RESET = 15'd1229;
	localparam logic [LIM_W-1:0]  ALIM_RESET = 15'd3277;

	// pipeline: s1 error/integral, s2 products, s3 p+d sum, s4 saturated sum,
	// s5 rounded shift, s6 range check, s7 divide by five and clamp
	localparam int NUM_STAGES = 7;
	typedef logic [NUM_STAGES-1:0] stage_en_t;

	// full command sum is kept as a saturated 64-bit value
	localparam int S_W = 64;
	localparam logic signed [S_W-1:0] S_MAX = {1'b0, {(S_W-1){1'b1}}};
	localparam logic signed [S_W-1:0] S_MIN = {1'b1, {(S_W-1){1'b0}}};

	// cmd = floor((S + 2560) / 5120) = floor(floor((S + 2560) / 1024) / 5)
	localparam int ROUND_BIAS  = 2560;
	localparam int SCALE_SHIFT = 10;
	localparam int T_W         = S_W + 1 - SCALE_SHIFT;

	// n / 5 for n < 2^19 as (n * ceil(2^21 / 5)) >> 21
	localparam int TN_W        = 19;
	localparam int RECIP       = 419431;
	localparam int RECIP_SHIFT = 21;
	localparam int QUO_W       = 16;
	localparam int CMD_W       = 17;

endpackage

// File: src/dual_axis_pid_velocity_controller.sv
// Two-axis PID velocity controller (linear and angular) with shared Q8.8 gains
// and a symmetric output clamp per axis.
//
// Input stream: tuser carries the item kind (target update, feedback update,
// control tick); tdata carries the linear and angular Q4.12 samples. Updates
// are absorbed at once and give no output. A tick accepted after both a target
// and a feedback update produces one output item on the master stream with the
// clamped linear and angular commands; earlier ticks and kind 3 are dropped.
//
// The configuration channel (cfg_valid/cfg_index/cfg_data) is always ready and
// should only be written while no tick is in flight.
//
// Throughput is one item per cycle while the receiver keeps m_axis_tready high.
// A tick's command passes through the seven-stage arithmetic pipeline (error and
// integral, multiply, sum, saturate, round, range check, divide by five and clamp).
// When the receiver stalls, items keep being accepted until the pipeline's
// empty slots are used up; then s_axis_tready drops. Reset clears stored
// targets, feedback, integrators, error history, flags and gains to defaults.
module dual_axis_pid_velocity_controller #(
	parameter int VALUE_WIDTH = 16,
	parameter int ACCUM_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// linear_value, angular_value
	input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
	// kind
	input  logic [dapv_pkg::KIND_W-1:0]               s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// linear_command, angular_command
	output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [dapv_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [dapv_pkg::CFG_DATA_W-1:0]           cfg_data
);
	import dapv_pkg::*;

	localparam int TDATA_W = ((2*VALUE_WIDTH+7)/8)*8;

	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [LIM_W-1:0]  llim_q, alim_q;

	logic                          go;
	stage_en_t                     en;
	logic signed [VALUE_WIDTH:0]   lin_err_s1, ang_err_s1;
	logic signed [VALUE_WIDTH+1:0] lin_derr_s1, ang_derr_s1;
	logic signed [ACCUM_WIDTH-1:0] lin_acc_s1, ang_acc_s1;
	logic signed [VALUE_WIDTH-1:0] lin_cmd, ang_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_RESET;
			ki_q   <= KI_RESET;
			kd_q   <= KD_RESET;
			llim_q <= LLIM_RESET;
			alim_q <= ALIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KP:   kp_q   <= cfg_data;
				CFG_KI:   ki_q   <= cfg_data;
				CFG_KD:   kd_q   <= cfg_data;
				CFG_LLIM: llim_q <= cfg_data[LIM_W-1:0];
				CFG_ALIM: alim_q <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dapv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.en        (en)
	);

	dapv_front #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.kind        (s_axis_tuser),
		.lin_value   ($signed(s_axis_tdata[VALUE_WIDTH-1:0])),
		.ang_value   ($signed(s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH])),
		.go          (go),
		.lin_err_s1  (lin_err_s1),
		.lin_derr_s1 (lin_derr_s1),
		.lin_acc_s1  (lin_acc_s1),
		.ang_err_s1  (ang_err_s1),
		.ang_derr_s1 (ang_derr_s1),
		.ang_acc_s1  (ang_acc_s1)
	);

	dapv_axis #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_lin (
		.clk       (clk),
		.en        (en),
		.kp        (kp_q),
		.ki        (ki_q),
		.kd        (kd_q),
		.limit_reg (llim_q),
		.err_s1    (lin_err_s1),
		.derr_s1   (lin_derr_s1),
		.acc_s1    (lin_acc_s1),
		.cmd       (lin_cmd)
	);

	dapv_axis #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_ang (
		.clk       (clk),
		.en        (en),
		.kp        (kp_q),
		.ki        (ki_q),
		.kd        (kd_q),
		.limit_reg (alim_q),
		.err_s1    (ang_err_s1),
		.derr_s1   (ang_derr_s1),
		.acc_s1    (ang_acc_s1),
		.cmd       (ang_cmd)
	);

	assign m_axis_tdata = TDATA_W'({ang_cmd, lin_cmd});

endmodule

// File: src/dapv_ctrl.sv
module dapv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                out_ready,
	output logic                in_ready,
	output logic                out_valid,
	output dapv_pkg::stage_en_t en
);
	import dapv_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES:0]   rdy;

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		rdy[NUM_STAGES] = out_ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= load;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign en        = rdy[NUM_STAGES-1:0];
	assign in_ready  = rdy[0];
	assign out_valid = valid_q[NUM_STAGES-1];

endmodule

// File: src/dapv_front.sv
module dapv_front #(
	parameter int VALUE_WIDTH = 16,
	parameter int ACCUM_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [dapv_pkg::KIND_W-1:0]         kind,
	input  logic signed [VALUE_WIDTH-1:0]       lin_value,
	input  logic signed [VALUE_WIDTH-1:0]       ang_value,
	output logic                                go,
	output logic signed [VALUE_WIDTH:0]         lin_err_s1,
	output logic signed [VALUE_WIDTH+1:0]       lin_derr_s1,
	output logic signed [ACCUM_WIDTH-1:0]       lin_acc_s1,
	output logic signed [VALUE_WIDTH:0]         ang_err_s1,
	output logic signed [VALUE_WIDTH+1:0]       ang_derr_s1,
	output logic signed [ACCUM_WIDTH-1:0]       ang_acc_s1
);
	import dapv_pkg::*;

	localparam int SUMA_W = ((ACCUM_WIDTH > VALUE_WIDTH + 1) ? ACCUM_WIDTH : VALUE_WIDTH + 1) + 1;
	localparam logic signed [SUMA_W-1:0] AMAX =
		{{(SUMA_W-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUMA_W-1:0] AMIN = ~AMAX;

	logic signed [VALUE_WIDTH-1:0] tgt_lin_q, tgt_ang_q, meas_lin_q, meas_ang_q;
	logic                          tgt_present_q, meas_present_q;
	logic signed [ACCUM_WIDTH-1:0] lin_acc_q, ang_acc_q;
	logic signed [VALUE_WIDTH:0]   lin_last_q, ang_last_q;

	logic                          accept;
	logic signed [VALUE_WIDTH:0]   lin_err, ang_err;
	logic signed [ACCUM_WIDTH-1:0] lin_acc_nxt, ang_acc_nxt;

	function automatic logic signed [ACCUM_WIDTH-1:0] acc_sat(
		input logic signed [ACCUM_WIDTH-1:0] acc,
		input logic signed [VALUE_WIDTH:0]   err
	);
		logic signed [SUMA_W-1:0] sum;
		sum = SUMA_W'(acc) + SUMA_W'(err);
		if (sum > AMAX) begin
			sum = AMAX;
		end else if (sum < AMIN) begin
			sum = AMIN;
		end
		return ACCUM_WIDTH'(sum);
	endfunction

	assign accept = in_valid && in_ready;
	assign go     = accept && (kind == KIND_TICK) && tgt_present_q && meas_present_q;

	always_comb begin
		lin_err     = (VALUE_WIDTH+1)'(tgt_lin_q) - (VALUE_WIDTH+1)'(meas_lin_q);
		ang_err     = (VALUE_WIDTH+1)'(tgt_ang_q) - (VALUE_WIDTH+1)'(meas_ang_q);
		lin_acc_nxt = acc_sat(lin_acc_q, lin_err);
		ang_acc_nxt = acc_sat(ang_acc_q, ang_err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_lin_q      <= '0;
			tgt_ang_q      <= '0;
			meas_lin_q     <= '0;
			meas_ang_q     <= '0;
			tgt_present_q  <= 1'b0;
			meas_present_q <= 1'b0;
			lin_acc_q      <= '0;
			ang_acc_q      <= '0;
			lin_last_q     <= '0;
			ang_last_q     <= '0;
		end else if (accept) begin
			case (kind)
				KIND_TARGET: begin
					tgt_lin_q     <= lin_value;
					tgt_ang_q     <= ang_value;
					tgt_present_q <= 1'b1;
				end
				KIND_FEEDBACK: begin
					meas_lin_q     <= lin_value;
					meas_ang_q     <= ang_value;
					meas_present_q <= 1'b1;
				end
				KIND_TICK: begin
					if (tgt_present_q && meas_present_q) begin
						lin_acc_q  <= lin_acc_nxt;
						ang_acc_q  <= ang_acc_nxt;
						lin_last_q <= lin_err;
						ang_last_q <= ang_err;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			lin_err_s1  <= lin_err;
			lin_derr_s1 <= (VALUE_WIDTH+2)'(lin_err) - (VALUE_WIDTH+2)'(lin_last_q);
			lin_acc_s1  <= lin_acc_nxt;
			ang_err_s1  <= ang_err;
			ang_derr_s1 <= (VALUE_WIDTH+2)'(ang_err) - (VALUE_WIDTH+2)'(ang_last_q);
			ang_acc_s1  <= ang_acc_nxt;
		end
	end

endmodule

// File: src/dapv_axis.sv
module dapv_axis #(
	parameter int VALUE_WIDTH = 16,
	parameter int ACCUM_WIDTH = 32
) (
	input  logic                              clk,
	input  dapv_pkg::stage_en_t               en,
	input  logic [dapv_pkg::GAIN_W-1:0]       kp,
	input  logic [dapv_pkg::GAIN_W-1:0]       ki,
	input  logic [dapv_pkg::GAIN_W-1:0]       kd,
	input  logic [dapv_pkg::LIM_W-1:0]        limit_reg,
	input  logic signed [VALUE_WIDTH:0]       err_s1,
	input  logic signed [VALUE_WIDTH+1:0]     derr_s1,
	input  logic signed [ACCUM_WIDTH-1:0]     acc_s1,
	output logic signed [VALUE_WIDTH-1:0]     cmd
);
	import dapv_pkg::*;

	localparam int PK_W  = VALUE_WIDTH + 18;
	localparam int PD_W  = VALUE_WIDTH + 19;
	localparam int PI_W  = ACCUM_WIDTH + 17;
	localparam int SPD_W = VALUE_WIDTH + 29;
	localparam int SUM_W = ((SPD_W > PI_W) ? SPD_W : PI_W) + 1;
	localparam longint VMAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;

	logic signed [PK_W-1:0]     pk_s2;
	logic signed [PD_W-1:0]     pd_s2;
	logic signed [PI_W-1:0]     pi_s2;
	logic signed [SPD_W-1:0]    spd_s3;
	logic signed [PI_W-1:0]     pi_s3;
	logic signed [S_W-1:0]      sum_s4;
	logic signed [T_W-1:0]      t_s5;
	logic                       hi_s6, lo_s6;
	logic [TN_W-1:0]            tn_s6;
	logic signed [VALUE_WIDTH-1:0] cmd_s7;

	logic [LIM_W-1:0]           lim;
	logic [LIM_W+2:0]           lim5;
	logic [TN_W-1:0]            hi_th;
	logic signed [SUM_W-1:0]    sum;
	logic signed [T_W:0]        u;
	logic [2*TN_W-1:0]          prod;
	logic [QUO_W-1:0]           quo;
	logic signed [CMD_W-1:0]    lim_s, q, sel;

	always_comb begin
		lim   = (longint'(limit_reg) > VMAX) ? LIM_W'(VMAX) : limit_reg;
		lim5  = (LIM_W+3)'(lim) * (LIM_W+3)'(5);
		hi_th = {lim5, 1'b0} + TN_W'(5);
		sum   = SUM_W'(spd_s3) + SUM_W'(pi_s3);
		u     = (T_W+1)'(t_s5) + (T_W+1)'($signed({1'b0, lim5}));
		prod  = (2*TN_W)'(tn_s6) * (2*TN_W)'(RECIP);
		quo   = prod[RECIP_SHIFT +: QUO_W];
		lim_s = $signed({2'b00, lim});
		q     = $signed({1'b0, quo}) - lim_s;
		if (hi_s6) begin
			sel = lim_s;
		end else if (lo_s6) begin
			sel = -lim_s;
		end else begin
			sel = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pk_s2 <= $signed({1'b0, kp}) * err_s1;
			pd_s2 <= $signed({1'b0, kd}) * derr_s1;
			pi_s2 <= $signed({1'b0, ki}) * acc_s1;
		end
		if (en[2]) begin
			spd_s3 <= SPD_W'(pk_s2) * SPD_W'(20) + SPD_W'(pd_s2) * SPD_W'(400);
			pi_s3  <= pi_s2;
		end
		if (en[3]) begin
			if (sum > S_MAX) begin
				sum_s4 <= S_MAX;
			end else if (sum < S_MIN) begin
				sum_s4 <= S_MIN;
			end else begin
				sum_s4 <= S_W'(sum);
			end
		end
		if (en[4]) begin
			t_s5 <= T_W'(((S_W+1)'(sum_s4) + (S_W+1)'(ROUND_BIAS)) >>> SCALE_SHIFT);
		end
		// u = T + 5L; result fits the limit only when 0 <= u <= 10L + 4
		if (en[5]) begin
			hi_s6 <= (u >= $signed({1'b0, hi_th}));
			lo_s6 <= u[T_W];
			tn_s6 <= u[TN_W-1:0];
		end
		if (en[6]) begin
			cmd_s7 <= VALUE_WIDTH'(sel);
		end
	end

	assign cmd = cmd_s7;

endmodule

// File: tb/testbench.sv
module testbench;
	import dapv_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam longint ACC_HI   = 64'sd2147483647;
	localparam longint ACC_LO   = -64'sd2147483648;
	localparam longint SUM_HI   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SUM_LO   = 64'sh8000_0000_0000_0000;
	localparam longint CMD_HI   = 64'sd32767;
	localparam longint SCALE    = 64'sd5120;
	localparam int     SETTLE   = 16;
	localparam int     N_DIR    = 23;
	localparam int     SAT_RUN  = 8;

	typedef struct packed {
		logic signed [15:0] ang;
		logic signed [15:0] lin;
	} cmd_pair_t;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		bit                 typed;
		bit                 produce;
		logic signed [15:0] lin_cmd;
		logic signed [15:0] ang_cmd;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n        = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [31:0]              s_axis_tdata  = '0;
	logic [KIND_W-1:0]        s_axis_tuser  = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [31:0]              m_axis_tdata;
	logic                     cfg_valid     = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index     = '0;
	logic [CFG_DATA_W-1:0]    cfg_data      = '0;

	// predictor copy of the registers and loop state
	logic [15:0] kp_gain   = KP_RESET;
	logic [15:0] ki_gain   = KI_RESET;
	logic [15:0] kd_gain   = KD_RESET;
	logic [14:0] lin_limit = LLIM_RESET;
	logic [14:0] ang_limit = ALIM_RESET;
	longint tgt_lin = 0, tgt_ang = 0, fb_lin = 0, fb_ang = 0;
	longint integ_lin = 0, integ_ang = 0, prev_err_lin = 0, prev_err_ang = 0;
	bit     tgt_seen = 0, fb_seen = 0;

	cmd_pair_t pending_cmds [$];
	int        mismatches   = 0;
	int        tx_idle_pct  = 0;
	int        rx_stall_pct = 0;

	dir_row_t dir_rows [N_DIR] = '{
		'{KIND_TICK,     16'sh1234,   16'sh8001,   1, 0, 16'sd0,    16'sd0},
		'{KIND_FEEDBACK, 16'sd0,      16'sd0,      1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      1, 0, 16'sd0,    16'sd0},
		'{KIND_UNUSED,   16'sh7FFF,   16'sh8000,   1, 0, 16'sd0,    16'sd0},
		'{KIND_TARGET,   16'sd4096,   -16'sd4096,  1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      1, 1, 16'sd1229, -16'sd3277},
		'{KIND_UNUSED,   16'shFFFF,   16'shFFFF,   1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'shFFFF,   16'sh0000,   0, 0, 16'sd0,    16'sd0},
		'{KIND_TARGET,   16'sh7FFF,   16'sh8000,   1, 0, 16'sd0,    16'sd0},
		'{KIND_FEEDBACK, 16'sh8000,   16'sh7FFF,   1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      1, 1, 16'sd1229, -16'sd3277},
		'{KIND_TICK,     16'sd0,      16'sd0,      1, 1, 16'sd1229, -16'sd3277},
		'{KIND_FEEDBACK, 16'sh7FFF,   16'sh8000,   1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      0, 0, 16'sd0,    16'sd0},
		'{KIND_TARGET,   16'sd0,      16'sd0,      1, 0, 16'sd0,    16'sd0},
		'{KIND_FEEDBACK, 16'sd0,      16'sd0,      1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      0, 0, 16'sd0,    16'sd0},
		'{KIND_TARGET,   16'sd100,    -16'sd50,    1, 0, 16'sd0,    16'sd0},
		'{KIND_FEEDBACK, 16'sd40,     16'sd25,     1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      0, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      0, 0, 16'sd0,    16'sd0},
		'{KIND_TARGET,   -16'sd1,     16'sd1,      1, 0, 16'sd0,    16'sd0},
		'{KIND_TICK,     16'sd0,      16'sd0,      0, 0, 16'sd0,    16'sd0}
	};

	dual_axis_pid_velocity_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// one axis of the loop: integrate, sum the three terms, round, clamp
	function automatic logic signed [15:0] axis_command(input longint tgt, input longint meas,
			input longint lim_reg, inout longint integ, inout longint prev_err);
		longint err, acc, sum, i_term, quo, rem, lim;
		err = tgt - meas;
		acc = integ + err;
		if (acc > ACC_HI) acc = ACC_HI;
		if (acc < ACC_LO) acc = ACC_LO;
		integ = acc;
		sum = 20 * longint'(kp_gain) * err + 400 * longint'(kd_gain) * (err - prev_err);
		i_term = longint'(ki_gain) * acc;
		if (i_term > 0 && sum > SUM_HI - i_term)
			sum = SUM_HI;
		else if (i_term < 0 && sum < SUM_LO - i_term)
			sum = SUM_LO;
		else
			sum = sum + i_term;
		prev_err = err;
		quo = sum / SCALE;
		rem = sum % SCALE;
		if (rem < 0) begin
			quo -= 1;
			rem += SCALE;
		end
		if (rem >= SCALE / 2) quo += 1;
		lim = lim_reg;
		if (lim > CMD_HI) lim = CMD_HI;
		if (quo > lim) quo = lim;
		if (quo < -lim) quo = -lim;
		return quo[15:0];
	endfunction

	function automatic bit predict_item(input logic [KIND_W-1:0] kind,
			input logic signed [15:0] lin, input logic signed [15:0] ang,
			output logic signed [15:0] lin_cmd, output logic signed [15:0] ang_cmd);
		lin_cmd = '0;
		ang_cmd = '0;
		if (kind == KIND_TARGET) begin
			tgt_lin  = lin;
			tgt_ang  = ang;
			tgt_seen = 1;
			return 0;
		end
		if (kind == KIND_FEEDBACK) begin
			fb_lin  = lin;
			fb_ang  = ang;
			fb_seen = 1;
			return 0;
		end
		if (kind != KIND_TICK || !tgt_seen || !fb_seen)
			return 0;
		lin_cmd = axis_command(tgt_lin, fb_lin, longint'(lin_limit), integ_lin, prev_err_lin);
		ang_cmd = axis_command(tgt_ang, fb_ang, longint'(ang_limit), integ_ang, prev_err_ang);
		return 1;
	endfunction

	function automatic logic [15:0] rand_sample();
		if ($urandom_range(0, 1) == 1)
			return 16'($urandom);
		return 16'($urandom_range(0, 4096)) - 16'd2048;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 10) $display("%s", msg);
		mismatches++;
	endtask

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [15:0] lin,
			input logic [15:0] ang);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {ang, lin};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic issue(input logic [KIND_W-1:0] kind, input logic [15:0] lin,
			input logic [15:0] ang);
		logic signed [15:0] lc, ac;
		send_item(kind, lin, ang);
		if (predict_item(kind, lin, ang, lc, ac))
			pending_cmds.push_back({ac, lc});
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_KP:   kp_gain   = value;
			CFG_KI:   ki_gain   = value;
			CFG_KD:   kd_gain   = value;
			CFG_LLIM: lin_limit = value[14:0];
			CFG_ALIM: ang_limit = value[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// the block drops some ticks silently, so leave extra cycles after the queue empties
	task automatic drain();
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cmd_pair_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_cmds.size() == 0) begin
				report_mismatch($sformatf("unexpected command lin=%0d ang=%0d",
					got.lin, got.ang));
			end else begin
				want = pending_cmds.pop_front();
				if (got.lin !== want.lin)
					report_mismatch($sformatf("linear command: expected %0d, got %0d",
						want.lin, got.lin));
				if (got.ang !== want.ang)
					report_mismatch($sformatf("angular command: expected %0d, got %0d",
						want.ang, got.ang));
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	initial begin
		logic signed [15:0] lc, ac;
		bit                 produced;
		int                 r;
		logic [KIND_W-1:0]  kind;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset gains
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].kind, dir_rows[i].lin, dir_rows[i].ang);
			produced = predict_item(dir_rows[i].kind, dir_rows[i].lin, dir_rows[i].ang,
				lc, ac);
			if (dir_rows[i].typed) begin
				produced = dir_rows[i].produce;
				lc       = dir_rows[i].lin_cmd;
				ac       = dir_rows[i].ang_cmd;
			end
			if (produced) pending_cmds.push_back({ac, lc});
		end
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < 10; p++) begin
			drain();
			case (p % 5)
				0: begin
					write_reg(CFG_KP, 16'($urandom_range(128, 1024)));
					write_reg(CFG_KI, 16'($urandom_range(0, 64)));
					write_reg(CFG_KD, 16'($urandom_range(0, 128)));
					write_reg(CFG_LLIM, 16'($urandom_range(1000, 32767)));
					write_reg(CFG_ALIM, 16'($urandom_range(1000, 32767)));
				end
				1: begin
					write_reg(CFG_KP, 16'($urandom));
					write_reg(CFG_KI, 16'($urandom));
					write_reg(CFG_KD, 16'($urandom));
					write_reg(CFG_LLIM, 16'd0);
					write_reg(CFG_ALIM, 16'd0);
				end
				2: begin
					write_reg(CFG_KP, 16'hFFFF);
					write_reg(CFG_KI, 16'hFFFF);
					write_reg(CFG_KD, 16'hFFFF);
					write_reg(CFG_LLIM, 16'hFFFF);
					write_reg(CFG_ALIM, 16'h7FFF);
				end
				3: begin
					write_reg(CFG_KP, 16'($urandom));
					write_reg(CFG_KI, 16'($urandom));
					write_reg(CFG_KD, 16'($urandom));
					write_reg(CFG_LLIM, 16'($urandom));
					write_reg(CFG_ALIM, 16'($urandom));
					// indexes past the register list must not disturb anything
					for (int i = int'(CFG_ALIM) + 1; i < (1 << CFG_IDX_W); i++)
						write_reg(CFG_IDX_W'(i), 16'($urandom));
				end
				default: begin
					write_reg(CFG_KP, 16'd0);
					write_reg(CFG_KI, 16'd0);
					write_reg(CFG_KD, 16'd0);
					write_reg(CFG_LLIM, 16'h7FFF);
					write_reg(CFG_ALIM, 16'hFFFF);
				end
			endcase
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
				default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
			endcase
			repeat (145) begin
				r = $urandom_range(0, 99);
				if (r < 22)
					kind = KIND_TARGET;
				else if (r < 44)
					kind = KIND_FEEDBACK;
				else if (r < 95)
					kind = KIND_TICK;
				else
					kind = KIND_UNUSED;
				issue(kind, rand_sample(), rand_sample());
			end
			s_axis_tvalid <= 1'b0;
		end

		// full-scale error on both integrators one way, then back the other way
		drain();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		write_reg(CFG_KP, 16'd0);
		write_reg(CFG_KI, 16'd1);
		write_reg(CFG_KD, 16'd0);
		write_reg(CFG_LLIM, 16'hFFFF);
		write_reg(CFG_ALIM, 16'h7FFF);
		issue(KIND_TARGET, 16'h7FFF, 16'h8000);
		issue(KIND_FEEDBACK, 16'h8000, 16'h7FFF);
		repeat (SAT_RUN) issue(KIND_TICK, 16'($urandom), 16'($urandom));
		issue(KIND_TARGET, 16'h8000, 16'h7FFF);
		issue(KIND_FEEDBACK, 16'h7FFF, 16'h8000);
		repeat (2 * SAT_RUN) issue(KIND_TICK, 16'($urandom), 16'($urandom));
		s_axis_tvalid <= 1'b0;

		drain();
		if (mismatches == 0 && pending_cmds.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
